FILE: rtl/nrsh_pkg.sv
// Package for the nearest ray/segment hit unit.
// Holds the shared types, codes and constants; it depends on nothing else.
package nrsh_pkg;

    localparam int CoordFracBits = 8;
    localparam int OffW          = 16;
    localparam int RayW          = 26;
    localparam int ProdW         = 52;
    localparam int HalfW         = 26;
    localparam int OffUp         = (CoordFracBits >= 8) ? CoordFracBits - 8 : 0;
    localparam int OffDn         = (CoordFracBits < 8) ? 8 - CoordFracBits : 0;

    typedef logic signed [23:0]      t_coord;
    typedef logic signed [24:0]      t_delta;
    typedef logic signed [RayW-1:0]  t_ray;
    typedef logic signed [ProdW-1:0] t_prod;
    typedef logic [ProdW-1:0]        t_mag;

    typedef logic [1:0] t_mode;
    localparam t_mode ModeClear = 2'd0;
    localparam t_mode ModeLoad  = 2'd1;
    localparam t_mode ModeCast  = 2'd2;

    typedef logic [1:0] t_cfg_addr;
    localparam t_cfg_addr CfgPlayerX   = 2'd0;
    localparam t_cfg_addr CfgPlayerY   = 2'd1;
    localparam t_cfg_addr CfgFanOffset = 2'd2;

    localparam logic [7:0] FanOffsetReset = 8'd26;

    typedef struct packed {
        t_coord by;
        t_coord bx;
        t_coord ay;
        t_coord ax;
    } t_seg;

    // Request to one interpolation unit: hit = a + delta * n2 / den, rounded.
    typedef struct packed {
        logic   start;
        t_coord a;
        t_delta delta;
        t_mag   n2;
        t_mag   den;
    } t_lerp_req;

    // Fan offset brought from Q0.8 to the coordinate fraction width.
    function automatic logic [OffW-1:0] scale_offset(input logic [7:0] v);
        logic [OffW-1:0] w;
        w = OffW'(v) << OffUp;
        return w >> OffDn;
    endfunction

endpackage

FILE: rtl/nrsh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the segment table; depends on nothing else.
module nrsh_ram #(
    parameter int Width = 96,
    parameter int Depth = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                         i_wdata,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/nrsh_lerp.sv
// Interpolation unit: a + delta * n2 / den rounded to nearest, ties away from zero.
// One multiply step, then a restoring divider one quotient bit per cycle. Uses nrsh_pkg.
module nrsh_lerp
    import nrsh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lerp_req i_req,
    output logic      o_done,
    output t_coord    o_hit
);

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_MUL  = 6'b000010,
        L_PREP = 6'b000100,
        L_DIV  = 6'b001000,
        L_FIN  = 6'b010000,
        L_DONE = 6'b100000
    } t_lstate;

    t_lstate            r_state;
    logic               r_neg;
    t_coord             r_a;
    logic [24:0]        r_mag;
    t_mag               r_n2;
    t_mag               r_den;
    logic [50:0]        r_plo;
    logic [50:0]        r_phi;
    logic [ProdW:0]     r_rem;
    logic [HalfW-1:0]   r_qsh;
    logic [4:0]         r_cnt;
    t_coord             r_hit;

    logic [77:0]        w_dividend;
    logic [ProdW:0]     w_trial;
    logic               w_ge;
    logic [26:0]        w_sum;

    assign w_dividend = {r_phi, 26'b0} + 78'(r_plo) + 78'(r_den >> 1);
    assign w_trial    = {r_rem[ProdW-1:0], r_qsh[HalfW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_den});
    assign w_sum      = r_neg ? (27'(r_a) - 27'(r_qsh)) : (27'(r_a) + 27'(r_qsh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.delta[24];
                        r_mag   <= i_req.delta[24] ? 25'(-i_req.delta) : 25'(i_req.delta);
                        r_a     <= i_req.a;
                        r_n2    <= i_req.n2;
                        r_den   <= i_req.den;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_plo   <= 51'(r_mag * r_n2[HalfW-1:0]);
                    r_phi   <= 51'(r_mag * r_n2[ProdW-1:HalfW]);
                    r_state <= L_PREP;
                end
                L_PREP: begin
                    // The quotient fits 26 bits, so the upper part is already below den.
                    r_rem   <= {1'b0, w_dividend[77:26]};
                    r_qsh   <= w_dividend[25:0];
                    r_cnt   <= '0;
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    r_rem   <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
                    r_qsh   <= {r_qsh[HalfW-2:0], w_ge};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'(HalfW - 1)) begin
                        r_state <= L_FIN;
                    end
                end
                L_FIN: begin
                    r_hit   <= w_sum[23:0];
                    r_state <= L_DONE;
                end
                L_DONE: begin
                    r_state <= L_IDLE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == L_DONE);
    assign o_hit  = r_hit;

endmodule

FILE: rtl/nearest_ray_segment_hit_unit.sv
// Top level of the nearest ray/segment hit unit: segment table, fan sequencer and hit test.
// Uses nrsh_pkg, nrsh_ram (segment table) and nrsh_lerp (hit point, one per axis).
//
//   channel  direction  tdata (low bit up)                                tuser
//   s_axis   in         seg_ax seg_ay seg_bx seg_by corner_x corner_y     mode
//   m_axis   out        hit_x hit_y                                       hit_found fan_index
//   cfg      in         write of player_x, player_y, fan_offset           -
//
// A cast walks the N stored segments in turn: each segment passes one table read and a
// six-step multiply/compare sequence, then the two dividers produce the hit point at one bit
// per cycle. A ray that hits nothing skips the dividers. One item is in work at a time; the
// next is taken when the fan has been handed out. A stalled output holds the sequencer
// before the next ray. Reset empties the table.
module nearest_ray_segment_hit_unit
    import nrsh_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // seg_ax, seg_ay, seg_bx, seg_by, corner_x, corner_y
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // hit_x, hit_y
    output logic [2:0]   m_axis_tuser,  // hit_found, fan_index
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  t_cfg_addr    i_cfg_addr,
    input  logic [23:0]  i_cfg_wdata
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_RAY  = 12'b000000000010,
        S_RD   = 12'b000000000100,
        S_LD   = 12'b000000001000,
        S_MUL  = 12'b000000010000,
        S_SUM  = 12'b000000100000,
        S_CMPM = 12'b000001000000,
        S_CMPA = 12'b000010000000,
        S_CMP  = 12'b000100000000,
        S_LERP = 12'b001000000000,
        S_WAIT = 12'b010000000000,
        S_EMIT = 12'b100000000000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [1:0]      r_k;
    t_coord          r_px;
    t_coord          r_py;
    logic [7:0]      r_fan_off;
    t_coord          r_cx;
    t_coord          r_cy;
    logic [OffW-1:0] r_off;
    t_ray            r_rdx, r_rdy;
    t_ray            r_tdx, r_tdy, r_ex, r_ey;
    t_coord          r_ax, r_ay;
    t_prod           r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    t_mag            r_den, r_n1, r_n2;
    logic            r_hit;
    t_mag            r_all, r_alh, r_ahl, r_ahh, r_ball, r_blh, r_bhl, r_bhh;
    logic [103:0]    r_lhs, r_rhs;
    logic            r_found;
    t_mag            r_bn1, r_bden, r_bn2;
    t_coord          r_bax, r_bay;
    t_delta          r_btdx, r_btdy;
    t_coord          r_hx, r_hy;
    logic            r_ovalid;
    logic [47:0]     r_odata;
    logic [2:0]      r_ouser;
    logic            r_olast;

    logic            w_in_acc;
    t_mode           w_mode;
    logic            w_we;
    t_seg            w_wseg;
    logic [95:0]     w_rdata;
    t_seg            w_rseg;
    t_ray            w_shift;
    t_prod           w_den, w_n2, w_n1;
    logic            w_neg;
    t_prod           w_den_n, w_n2_n, w_n1_n;
    logic            w_take;
    logic            w_out_free;
    t_lerp_req       w_req_x, w_req_y;
    logic            w_done_x, w_done_y;
    t_coord          w_hit_x, w_hit_y;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = s_axis_tuser;
    assign w_we          = w_in_acc && (w_mode == ModeLoad) && (r_count < CW'(MAX_SEGMENTS));
    assign w_wseg.ax     = s_axis_tdata[23:0];
    assign w_wseg.ay     = s_axis_tdata[47:24];
    assign w_wseg.bx     = s_axis_tdata[71:48];
    assign w_wseg.by     = s_axis_tdata[95:72];

    nrsh_ram #(
        .Width(96),
        .Depth(MAX_SEGMENTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(w_wseg),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    assign w_rseg = t_seg'(w_rdata);

    // Ray k aims through the corner moved by (k - 1) times the offset on both axes.
    always_comb begin
        case (r_k)
            2'd0:    w_shift = -RayW'(r_off);
            2'd2:    w_shift = RayW'(r_off);
            default: w_shift = '0;
        endcase
    end

    assign w_den   = r_p0 - r_p1;
    assign w_n2    = r_p2 - r_p3;
    assign w_n1    = r_p4 - r_p5;
    assign w_neg   = w_den[ProdW-1];
    assign w_den_n = w_neg ? -w_den : w_den;
    assign w_n2_n  = w_neg ? -w_n2 : w_n2;
    assign w_n1_n  = w_neg ? -w_n1 : w_n1;

    // Strict compare keeps the earlier segment on an equal ray parameter.
    assign w_take     = r_hit && (!r_found || (r_lhs < r_rhs));
    assign w_out_free = !r_ovalid || m_axis_tready;

    assign w_req_x.start = (r_state == S_LERP) && r_found;
    assign w_req_x.a     = r_bax;
    assign w_req_x.delta = r_btdx;
    assign w_req_x.n2    = r_bn2;
    assign w_req_x.den   = r_bden;
    assign w_req_y.start = (r_state == S_LERP) && r_found;
    assign w_req_y.a     = r_bay;
    assign w_req_y.delta = r_btdy;
    assign w_req_y.n2    = r_bn2;
    assign w_req_y.den   = r_bden;

    nrsh_lerp u_lerp_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req_x),
        .o_done (w_done_x),
        .o_hit  (w_hit_x)
    );

    nrsh_lerp u_lerp_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req_y),
        .o_done (w_done_y),
        .o_hit  (w_hit_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_k       <= '0;
            r_found   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_px      <= '0;
            r_py      <= '0;
            r_fan_off <= FanOffsetReset;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CfgPlayerX:   r_px      <= i_cfg_wdata;
                    CfgPlayerY:   r_py      <= i_cfg_wdata;
                    CfgFanOffset: r_fan_off <= i_cfg_wdata[7:0];
                    default:      ;
                endcase
            end

            if ((r_state == S_EMIT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (w_mode)
                            ModeClear: r_count <= '0;
                            ModeLoad:  if (w_we) r_count <= r_count + CW'(1);
                            ModeCast: begin
                                r_cx    <= s_axis_tdata[119:96];
                                r_cy    <= s_axis_tdata[143:120];
                                r_off   <= scale_offset(r_fan_off);
                                r_k     <= '0;
                                r_state <= S_RAY;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RAY: begin
                    r_rdx   <= RayW'(r_cx) + w_shift - RayW'(r_px);
                    r_rdy   <= RayW'(r_cy) + w_shift - RayW'(r_py);
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_bn1   <= '0;
                    r_bden  <= t_mag'(1);
                    r_state <= (r_count == '0) ? S_LERP : S_RD;
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_tdx   <= RayW'(w_rseg.bx) - RayW'(w_rseg.ax);
                    r_tdy   <= RayW'(w_rseg.by) - RayW'(w_rseg.ay);
                    r_ex    <= RayW'(w_rseg.ax) - RayW'(r_px);
                    r_ey    <= RayW'(w_rseg.ay) - RayW'(r_py);
                    r_ax    <= w_rseg.ax;
                    r_ay    <= w_rseg.ay;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p0    <= r_tdx * r_rdy;
                    r_p1    <= r_tdy * r_rdx;
                    r_p2    <= r_rdx * r_ey;
                    r_p3    <= r_rdy * r_ex;
                    r_p4    <= r_ey * r_tdx;
                    r_p5    <= r_ex * r_tdy;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // A zero cross product (ray and segment parallel) counts as no hit.
                    r_hit   <= (w_den != '0) && !w_n1_n[ProdW-1] && !w_n2_n[ProdW-1]
                               && (w_n2_n <= w_den_n);
                    r_den   <= t_mag'(w_den_n);
                    r_n1    <= t_mag'(w_n1_n);
                    r_n2    <= t_mag'(w_n2_n);
                    r_state <= S_CMPM;
                end
                S_CMPM: begin
                    r_all   <= r_n1[HalfW-1:0] * r_bden[HalfW-1:0];
                    r_alh   <= r_n1[HalfW-1:0] * r_bden[ProdW-1:HalfW];
                    r_ahl   <= r_n1[ProdW-1:HalfW] * r_bden[HalfW-1:0];
                    r_ahh   <= r_n1[ProdW-1:HalfW] * r_bden[ProdW-1:HalfW];
                    r_ball  <= r_bn1[HalfW-1:0] * r_den[HalfW-1:0];
                    r_blh   <= r_bn1[HalfW-1:0] * r_den[ProdW-1:HalfW];
                    r_bhl   <= r_bn1[ProdW-1:HalfW] * r_den[HalfW-1:0];
                    r_bhh   <= r_bn1[ProdW-1:HalfW] * r_den[ProdW-1:HalfW];
                    r_state <= S_CMPA;
                end
                S_CMPA: begin
                    r_lhs   <= (104'(r_ahh) << 52) + (104'(r_ahl) << 26)
                               + (104'(r_alh) << 26) + 104'(r_all);
                    r_rhs   <= (104'(r_bhh) << 52) + (104'(r_bhl) << 26)
                               + (104'(r_blh) << 26) + 104'(r_ball);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_take) begin
                        r_found <= 1'b1;
                        r_bn1   <= r_n1;
                        r_bden  <= r_den;
                        r_bn2   <= r_n2;
                        r_bax   <= r_ax;
                        r_bay   <= r_ay;
                        r_btdx  <= r_tdx[24:0];
                        r_btdy  <= r_tdy[24:0];
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= (r_idx + CW'(1) == r_count) ? S_LERP : S_RD;
                end
                S_LERP: begin
                    r_hx    <= '0;
                    r_hy    <= '0;
                    r_state <= r_found ? S_WAIT : S_EMIT;
                end
                S_WAIT: begin
                    if (w_done_x && w_done_y) begin
                        r_hx    <= w_hit_x;
                        r_hy    <= w_hit_y;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_odata  <= {r_hy, r_hx};
                        r_ouser  <= {r_k, r_found};
                        r_olast  <= (r_k == 2'd2);
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_RAY;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

FILE: rtl/nrsh_checker.sv
// Port-level checks for the nearest ray/segment hit unit, bound to its top level.
// Depends only on the top level's port names.
module nrsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A result that waits keeps its valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // The last marker sits on the third ray of a fan and only there.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:1] == 2'd2)))
        else $error("last marker does not match ray number");

    // A ray without a hit reports the origin of the coordinate system.
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == 48'd0))
        else $error("missed ray with nonzero point");

    // Rays of a fan follow in order: after a taken non-last ray comes the next number.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> (m_axis_tuser[2:1] == $past(m_axis_tuser[2:1]) + 2'd1))
        else $error("ray number out of order");

endmodule

bind nearest_ray_segment_hit_unit nrsh_checker u_nrsh_checker (.*);

FILE: dv/testbench.sv
// Testbench for the nearest ray/segment hit unit: segment table, three-ray fan casts
// and the player/offset registers, checked against an integer predictor of the fan.
// Depends on rtl/nrsh_pkg.sv and rtl/nearest_ray_segment_hit_unit.sv.
module testbench;
    import nrsh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumSeg = 64;
    // Mode code that the block ignores.
    localparam t_mode ModeUnused = 2'd3;

    typedef struct {
        logic signed [23:0] hx;
        logic signed [23:0] hy;
        logic               found;
        logic [1:0]         idx;
        logic               last;
    } t_hit;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    t_cfg_addr    i_cfg_addr = CfgPlayerX;
    logic [23:0]  i_cfg_wdata = '0;

    nearest_ray_segment_hit_unit #(.MAX_SEGMENTS(NumSeg)) uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    longint wall_ax[NumSeg], wall_ay[NumSeg], wall_bx[NumSeg], wall_by[NumSeg];
    int     wall_count;
    longint origin_x, origin_y;
    int     spread;
    t_hit   pending_hits[$];
    int     fail_count;
    longint cycle_count;
    bit     hold_off;
    bit     long_hold;

    // a + sign(delta) * round(|delta|*n2/den) with ties up, done on 128-bit values.
    function automatic longint lerp_axis(longint a, longint delta, longint n2, longint den);
        logic [127:0] num, q;
        longint mag;
        mag = (delta < 0) ? -delta : delta;
        num = 128'(mag) * 128'(n2) + 128'(den >> 1);
        q = num / 128'(den);
        return (delta < 0) ? a - longint'(q) : a + longint'(q);
    endfunction

    task automatic predict_ray(longint aim_x, longint aim_y, int k);
        longint rdx, rdy, tdx, tdy, ex, ey, den, n2, n1, best_n1, best_den, hx, hy;
        logic [127:0] lhs, rhs;
        bit found;
        t_hit h;
        rdx = aim_x - origin_x;
        rdy = aim_y - origin_y;
        found = 0; best_n1 = 0; best_den = 1; hx = 0; hy = 0;
        for (int i = 0; i < wall_count; i++) begin
            tdx = wall_bx[i] - wall_ax[i];
            tdy = wall_by[i] - wall_ay[i];
            ex = wall_ax[i] - origin_x;
            ey = wall_ay[i] - origin_y;
            den = tdx * rdy - tdy * rdx;
            n2 = rdx * ey - rdy * ex;
            n1 = ey * tdx - ex * tdy;
            if (den == 0) continue;
            if (den < 0) begin
                den = -den; n2 = -n2; n1 = -n1;
            end
            if (n1 < 0 || n2 < 0 || n2 > den) continue;
            lhs = 128'(n1) * 128'(best_den);
            rhs = 128'(best_n1) * 128'(den);
            if (!found || lhs < rhs) begin
                found = 1;
                best_n1 = n1;
                best_den = den;
                hx = lerp_axis(wall_ax[i], tdx, n2, den);
                hy = lerp_axis(wall_ay[i], tdy, n2, den);
            end
        end
        h.hx = hx[23:0];
        h.hy = hy[23:0];
        h.found = found;
        h.idx = 2'(k);
        h.last = (k == 2);
        pending_hits = {pending_hits, h};
    endtask

    function automatic longint sx(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    task automatic apply_item(t_mode mode, logic [143:0] data);
        longint cx, cy, off;
        case (mode)
            ModeClear: wall_count = 0;
            ModeLoad: begin
                if (wall_count < NumSeg) begin
                    wall_ax[wall_count] = sx(data[23:0]);
                    wall_ay[wall_count] = sx(data[47:24]);
                    wall_bx[wall_count] = sx(data[71:48]);
                    wall_by[wall_count] = sx(data[95:72]);
                    wall_count++;
                end
            end
            ModeCast: begin
                cx = sx(data[119:96]);
                cy = sx(data[143:120]);
                off = spread;
                for (int k = 0; k < 3; k++)
                    predict_ray(cx + (k - 1) * off, cy + (k - 1) * off, k);
            end
            default: ;
        endcase
    endtask

    // Sends one item; tvalid stays high into the next item unless a random gap drops it.
    task automatic send_item(t_mode mode, logic [143:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_item(mode, data);
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_addr addr, logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (addr)
            CfgPlayerX: origin_x = sx(val);
            CfgPlayerY: origin_y = sx(val);
            default:    spread = val[7:0];
        endcase
    endtask

    function automatic logic [143:0] pack_seg(logic [23:0] ax, ay, bx, by);
        return {48'd0, by, bx, ay, ax};
    endfunction

    function automatic logic [143:0] pack_corner(logic [23:0] x, y);
        return {y, x, 96'd0};
    endfunction

    // Small coordinate near the origin, so rays and walls meet often.
    function automatic logic [23:0] near_coord();
        return 24'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    function automatic logic [23:0] any_coord();
        return ($urandom_range(0, 3) == 0) ? 24'($urandom) : near_coord();
    endfunction

    task automatic test_directed();
        // Empty table gives three misses.
        send_item(ModeCast, pack_corner(24'd256, 24'd256));
        // A vertical wall crossed by the exact ray, a zero-length wall and one parallel to a ray.
        send_item(ModeLoad, pack_seg(24'd1024, -24'sd1024, 24'd1024, 24'd1024));
        send_item(ModeLoad, pack_seg(24'd0, 24'd512, 24'd0, 24'd512));
        send_item(ModeLoad, pack_seg(24'd512, 24'd512, 24'd1024, 24'd1024));
        send_item(ModeCast, pack_corner(24'd256, 24'd0));
        send_item(ModeCast, pack_corner(24'd0, 24'd256));
        send_item(ModeCast, pack_corner(24'd256, 24'd256));
        // Nearer wall loaded later, and an equal-distance copy.
        send_item(ModeLoad, pack_seg(24'd512, -24'sd1024, 24'd512, 24'd1024));
        send_item(ModeLoad, pack_seg(24'd512, -24'sd1024, 24'd512, 24'd1024));
        send_item(ModeCast, pack_corner(24'd256, 24'd10));
        // Ignored mode, then extremes of all fields.
        send_item(ModeUnused, {144{1'b1}});
        send_item(ModeLoad, pack_seg(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000));
        send_item(ModeCast, pack_corner(24'h7fffff, 24'h7fffff));
        send_item(ModeCast, pack_corner(24'h800000, 24'h800000));
        send_item(ModeCast, pack_corner(24'h000000, 24'h000000));
        send_item(ModeCast, {144{1'b1}});
        send_item(ModeClear, {144{1'b1}});
        send_item(ModeCast, pack_corner(24'd256, 24'd0));
        drain();
    endtask

    task automatic test_full_table();
        send_item(ModeClear, '0);
        for (int i = 0; i < NumSeg + 3; i++)
            send_item(ModeLoad, pack_seg(near_coord(), near_coord(), near_coord(),
                                         near_coord()));
        send_item(ModeCast, pack_corner(near_coord(), near_coord()));
        drain();
    endtask

    task automatic test_config();
        write_reg(CfgPlayerX, 24'h800000);
        write_reg(CfgPlayerY, 24'h7fffff);
        write_reg(CfgFanOffset, 24'd255);
        send_item(ModeCast, pack_corner(24'd0, 24'd0));
        send_item(ModeCast, pack_corner(24'h7fffff, 24'h800000));
        drain();
        write_reg(CfgFanOffset, 24'd0);
        write_reg(CfgPlayerX, 24'd100);
        write_reg(CfgPlayerY, -24'sd300);
        send_item(ModeCast, pack_corner(24'd900, 24'd77));
        drain();
    endtask

    // Well-formed table builds followed by casts, with some noise mixed in.
    task automatic test_random(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            write_reg(CfgPlayerX, ($urandom_range(0, 5) == 0) ? 24'($urandom) : near_coord());
            write_reg(CfgPlayerY, ($urandom_range(0, 5) == 0) ? 24'($urandom) : near_coord());
            write_reg(CfgFanOffset, 24'($urandom_range(0, 255)));
            send_item(ModeClear, 144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            sent++;
            repeat ($urandom_range(1, 8)) begin
                send_item(ModeLoad, {48'($urandom), any_coord(), any_coord(), any_coord(),
                                     any_coord()});
                sent++;
            end
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(ModeUnused,
                              144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
                else
                    send_item(ModeCast, {any_coord(), any_coord(), 96'({$urandom, $urandom,
                                                                        $urandom})});
                sent++;
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        send_item(ModeLoad, pack_seg(24'd1024, -24'sd1024, 24'd1024, 24'd1024));
        repeat (6) send_item(ModeCast, pack_corner(near_coord(), near_coord()));
        drain();
    endtask

    // Receiver stall pattern, with one long hold when requested.
    always @(posedge i_clk) begin
        if (long_hold) begin
            hold_off <= 1'b1;
            m_axis_tready <= 1'b0;
            long_hold <= 1'b0;
            repeat (800) @(posedge i_clk);
            hold_off <= 1'b0;
        end else if (!hold_off) begin
            m_axis_tready <= (cycle_count % 300 < 150) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_hit exp_hit;
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected result item");
                fail_count++;
            end else begin
                exp_hit = pending_hits.pop_front();
                if (m_axis_tdata[23:0] !== exp_hit.hx) begin
                    $error("hit_x expected %0d got %0d", exp_hit.hx,
                           $signed(m_axis_tdata[23:0]));
                    fail_count++;
                end
                if (m_axis_tdata[47:24] !== exp_hit.hy) begin
                    $error("hit_y expected %0d got %0d", exp_hit.hy,
                           $signed(m_axis_tdata[47:24]));
                    fail_count++;
                end
                if (m_axis_tuser[0] !== exp_hit.found) begin
                    $error("hit_found expected %0d got %0d", exp_hit.found, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tuser[2:1] !== exp_hit.idx) begin
                    $error("fan_index expected %0d got %0d", exp_hit.idx, m_axis_tuser[2:1]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_hit.last) begin
                    $error("fan_last expected %0d got %0d", exp_hit.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        fail_count = 0;
        hold_off = 0;
        long_hold = 0;
        wall_count = 0;
        origin_x = 0;
        origin_y = 0;
        spread = FanOffsetReset;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_config();
        test_backpressure();
        test_random(210);
        drain();
        if (pending_hits.size() == 0 && fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
